/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define TCBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on the rising clock edge
`define TCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/tcbp_pkg.sv */
package tcbp_pkg;

  localparam int unsigned LINE_BYTES = 20;
  localparam int unsigned ADDR_W     = $clog2(LINE_BYTES);
  localparam int unsigned CNT_W      = $clog2(LINE_BYTES + 2);

  localparam int unsigned MSG_LEN = 15;
  localparam int unsigned POS_W   = $clog2(MSG_LEN + 1);

  localparam int unsigned LVL_W = 7;
  localparam int unsigned MAG_W = 10;
  localparam int unsigned PWM_W = 14;

  localparam logic [LVL_W-1:0] LEVEL_MAX = 7'd100;
  localparam logic [MAG_W-1:0] MAG_CAP   = 10'd1000;
  localparam logic [PWM_W-1:0] PWM_MAX   = 14'd10000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam int unsigned TXT_W = MSG_LEN * 8;

  localparam logic [TXT_W-1:0] TXT_GET      = "GET";
  localparam int unsigned      TXT_GET_LEN  = 3;
  localparam logic [TXT_W-1:0] TXT_SET      = "SET";
  localparam int unsigned      TXT_SET_LEN  = 3;
  localparam logic [TXT_W-1:0] TXT_GTAIL    = " B1\r\n";
  localparam int unsigned      TXT_GTAIL_LEN = 5;
  localparam logic [TXT_W-1:0] TXT_STAIL    = " B1 ";
  localparam int unsigned      TXT_STAIL_LEN = 4;
  localparam logic [TXT_W-1:0] TXT_ECHO     = "B1 ";
  localparam int unsigned      TXT_ECHO_LEN = 3;
  localparam logic [TXT_W-1:0] TXT_ILLEGAL  = "ILLEGAL VALUE\r\n";
  localparam logic [TXT_W-1:0] TXT_UNIMPL   = "UNIMPLEMENTED\r\n";

  typedef enum logic [1:0] {
    REPLY_NONE    = 2'd0,
    REPLY_ECHO    = 2'd1,
    REPLY_ILLEGAL = 2'd2,
    REPLY_UNIMPL  = 2'd3
  } reply_kind_e;

  typedef struct packed {
    logic             done;
    reply_kind_e      kind;
    logic             lvl_we;
    logic [LVL_W-1:0] lvl;
  } scan_res_t;

  // k-th character of a text of n characters, first character in the upper bits
  function automatic logic [7:0] txt_pick(input logic [TXT_W-1:0] txt,
                                          input int unsigned n,
                                          input int unsigned k);
    return txt[(n - 1 - k) * 8 +: 8];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[CH_TAB:CH_CR], CH_SP};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

endpackage

/* src/tcbp_if.sv */
interface tcbp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tcbp_tx_if;
  import tcbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [7:0]       tx_byte;
  logic             last;
  logic [PWM_W-1:0] pwm_compare;

  modport source (output valid, output tx_byte, output last, output pwm_compare, input ready);
  modport sink   (input valid, input tx_byte, input last, input pwm_compare, output ready);
endinterface

/* src/tcbp_ram.sv */
module tcbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/tcbp_scan.sv */
module tcbp_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tcbp_pkg::CNT_W-1:0]  len_i,
  output logic [tcbp_pkg::ADDR_W-1:0] rd_addr_o,
  input  logic [7:0]               rd_data_i,
  output tcbp_pkg::scan_res_t      res_o
);
  import tcbp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PRIME = 7'b0000010,
    S_CMD   = 7'b0000100,
    S_GET   = 7'b0001000,
    S_SET   = 7'b0010000,
    S_SKIP  = 7'b0100000,
    S_DIGIT = 7'b1000000
  } scan_state_e;

  scan_state_e      state_q, state_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic             get_ok_q, get_ok_d;
  logic             set_ok_q, set_ok_d;
  logic             neg_q, neg_d;
  logic             nd_q, nd_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  scan_res_t        res_q, res_d;

  logic [CNT_W-1:0] cur;
  logic [7:0]       c;
  logic             fin;
  logic [3:0]       dig;
  logic [MAG_W+3:0] mag_acc;
  logic [MAG_W-1:0] mag_sat;
  logic             get_m;
  logic             set_m;

  assign c   = rd_data_i;
  assign cur = pos_q - CNT_W'(1);
  assign fin = (cur == len_q) || (c == CH_NUL);
  assign dig = 4'(c - CH_0);

  // one decimal step of the shared accumulator, saturating
  assign mag_acc = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {MAG_W'(0), dig};
  assign mag_sat = (mag_acc > (MAG_W + 4)'(MAG_CAP)) ? MAG_CAP : mag_acc[MAG_W-1:0];

  assign rd_addr_o = (pos_q < CNT_W'(LINE_BYTES)) ? pos_q[ADDR_W-1:0] : '0;

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    len_d    = len_q;
    get_ok_d = get_ok_q;
    set_ok_d = set_ok_q;
    neg_d    = neg_q;
    nd_d     = nd_q;
    mag_d    = mag_q;
    res_d    = res_q;
    res_d.done   = 1'b0;
    res_d.lvl_we = 1'b0;
    get_m = 1'b0;
    set_m = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          len_d    = len_i;
          pos_d    = '0;
          get_ok_d = 1'b1;
          set_ok_d = 1'b1;
          neg_d    = 1'b0;
          nd_d     = 1'b0;
          mag_d    = '0;
          state_d  = S_PRIME;
        end
      end
      S_PRIME: begin
        pos_d   = pos_q + CNT_W'(1);
        state_d = S_CMD;
      end
      S_CMD: begin
        pos_d = pos_q + CNT_W'(1);
        get_m = get_ok_q && (c == txt_pick(TXT_GET, TXT_GET_LEN, int'(cur)));
        set_m = set_ok_q && (c == txt_pick(TXT_SET, TXT_SET_LEN, int'(cur)));
        if (fin) begin
          res_d.done = 1'b1;
          res_d.kind = REPLY_UNIMPL;
          state_d    = S_IDLE;
        end else if (cur == CNT_W'(TXT_GET_LEN - 1)) begin
          if (get_m) begin
            state_d = S_GET;
          end else if (set_m) begin
            state_d = S_SET;
          end else begin
            res_d.done = 1'b1;
            res_d.kind = REPLY_UNIMPL;
            state_d    = S_IDLE;
          end
        end else begin
          get_ok_d = get_m;
          set_ok_d = set_m;
        end
      end
      S_GET: begin
        pos_d = pos_q + CNT_W'(1);
        if (fin) begin
          res_d.done = 1'b1;
          res_d.kind = ((cur == CNT_W'(6)) || (cur == CNT_W'(8))) ? REPLY_ECHO : REPLY_NONE;
          state_d    = S_IDLE;
        end else if ((cur == CNT_W'(8)) ||
                     (c != txt_pick(TXT_GTAIL, TXT_GTAIL_LEN, int'(cur) - 3))) begin
          res_d.done = 1'b1;
          res_d.kind = REPLY_NONE;
          state_d    = S_IDLE;
        end
      end
      S_SET: begin
        pos_d = pos_q + CNT_W'(1);
        if (fin || (c != txt_pick(TXT_STAIL, TXT_STAIL_LEN, int'(cur) - 3))) begin
          res_d.done = 1'b1;
          res_d.kind = REPLY_NONE;
          state_d    = S_IDLE;
        end else if (cur == CNT_W'(6)) begin
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        pos_d = pos_q + CNT_W'(1);
        if (fin) begin
          res_d.done = 1'b1;
          res_d.kind = REPLY_ILLEGAL;
          state_d    = S_IDLE;
        end else if (is_space(c)) begin
          state_d = S_SKIP;
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          neg_d   = (c == CH_MINUS);
          state_d = S_DIGIT;
        end else if (is_digit(c)) begin
          mag_d   = mag_sat;
          nd_d    = 1'b1;
          state_d = S_DIGIT;
        end else begin
          res_d.done = 1'b1;
          res_d.kind = REPLY_ILLEGAL;
          state_d    = S_IDLE;
        end
      end
      S_DIGIT: begin
        pos_d = pos_q + CNT_W'(1);
        if (!fin && is_digit(c)) begin
          mag_d = mag_sat;
          nd_d  = 1'b1;
        end else begin
          res_d.done = 1'b1;
          state_d    = S_IDLE;
          if (nd_q && (mag_q <= MAG_W'(LEVEL_MAX)) && (!neg_q || (mag_q == '0))) begin
            res_d.kind   = REPLY_ECHO;
            res_d.lvl_we = 1'b1;
            res_d.lvl    = mag_q[LVL_W-1:0];
          end else begin
            res_d.kind = REPLY_ILLEGAL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    len_q      <= len_d;
    get_ok_q   <= get_ok_d;
    set_ok_q   <= set_ok_d;
    neg_q      <= neg_d;
    nd_q       <= nd_d;
    mag_q      <= mag_d;
  end

  assign res_o = res_q;

endmodule

/* src/tcbp_reply.sv */
module tcbp_reply (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcbp_pkg::scan_res_t res_i,
  output logic                done_o,
  tcbp_tx_if.source           tx_o
);
  import tcbp_pkg::*;

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_PREP = 3'b010,
    R_EMIT = 3'b100
  } reply_state_e;

  reply_state_e     state_q, state_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  reply_kind_e      kind_q, kind_d;
  logic             valid_q, valid_d;
  logic [POS_W-1:0] k_q, k_d;
  logic [POS_W-1:0] n_q, n_d;
  logic [PWM_W-1:0] pwm_q, pwm_d;
  logic [3:0]       hun_q, hun_d;
  logic [3:0]       ten_q, ten_d;
  logic [3:0]       one_q, one_d;
  logic [1:0]       nd_q, nd_d;

  logic [LVL_W+7:0] recip;
  logic [3:0]       quo;
  logic [LVL_W-1:0] quo10;
  logic             is_last;
  logic [7:0]       byte_out;
  logic [POS_W-1:0] j;
  logic [POS_W-1:0] r;

  // divide by ten: multiply by 205 and drop eleven bits, exact below 128
  assign recip = {8'b0, lvl_q} * (LVL_W + 8)'(205);
  assign quo   = recip[LVL_W+7:11];
  assign quo10 = ({3'b0, quo} << 3) + ({3'b0, quo} << 1);

  assign is_last = (k_q == n_q - POS_W'(1));

  always_comb begin
    j        = k_q - POS_W'(TXT_ECHO_LEN);
    r        = POS_W'(nd_q) - POS_W'(1) - j;
    byte_out = CH_NUL;
    case (kind_q)
      REPLY_ECHO: begin
        if (k_q < POS_W'(TXT_ECHO_LEN)) begin
          byte_out = txt_pick(TXT_ECHO, TXT_ECHO_LEN, int'(k_q));
        end else if (j < POS_W'(nd_q)) begin
          case (r)
            POS_W'(0): byte_out = CH_0 + {4'b0, one_q};
            POS_W'(1): byte_out = CH_0 + {4'b0, ten_q};
            default:   byte_out = CH_0 + {4'b0, hun_q};
          endcase
        end else if (j == POS_W'(nd_q)) begin
          byte_out = CH_CR;
        end else begin
          byte_out = CH_LF;
        end
      end
      REPLY_ILLEGAL: byte_out = txt_pick(TXT_ILLEGAL, MSG_LEN, int'(k_q));
      REPLY_UNIMPL:  byte_out = txt_pick(TXT_UNIMPL, MSG_LEN, int'(k_q));
      default:       byte_out = CH_NUL;
    endcase
  end

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    kind_d  = kind_q;
    valid_d = valid_q;
    k_d     = k_q;
    n_d     = n_q;
    pwm_d   = pwm_q;
    hun_d   = hun_q;
    ten_d   = ten_q;
    one_d   = one_q;
    nd_d    = nd_q;
    done_o  = 1'b0;

    case (state_q)
      R_IDLE: begin
        if (res_i.done) begin
          if (res_i.lvl_we) begin
            lvl_d = res_i.lvl;
          end
          kind_d = res_i.kind;
          if (res_i.kind == REPLY_NONE) begin
            done_o = 1'b1;
          end else begin
            state_d = R_PREP;
          end
        end
      end
      R_PREP: begin
        pwm_d = PWM_W'(lvl_q) * PWM_W'(lvl_q);
        if (lvl_q >= LEVEL_MAX) begin
          hun_d = 4'd1;
          ten_d = 4'd0;
          one_d = 4'd0;
          nd_d  = 2'd3;
        end else begin
          hun_d = 4'd0;
          ten_d = quo;
          one_d = 4'(lvl_q - quo10);
          nd_d  = (quo != 4'd0) ? 2'd2 : 2'd1;
        end
        if (kind_q == REPLY_ECHO) begin
          n_d = POS_W'(TXT_ECHO_LEN + 2) + POS_W'(nd_d);
        end else begin
          n_d = POS_W'(MSG_LEN);
        end
        k_d     = '0;
        valid_d = 1'b1;
        state_d = R_EMIT;
      end
      R_EMIT: begin
        if (tx_o.ready) begin
          if (is_last) begin
            valid_d = 1'b0;
            done_o  = 1'b1;
            state_d = R_IDLE;
          end else begin
            k_d = k_q + POS_W'(1);
          end
        end
      end
      default: begin
        valid_d = 1'b0;
        state_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      lvl_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    k_q    <= k_d;
    n_q    <= n_d;
    pwm_q  <= pwm_d;
    hun_q  <= hun_d;
    ten_q  <= ten_d;
    one_q  <= one_d;
    nd_q   <= nd_d;
  end

  assign tx_o.valid       = valid_q;
  assign tx_o.tx_byte     = byte_out;
  assign tx_o.last        = is_last;
  assign tx_o.pwm_compare = pwm_q;

endmodule

/* src/text_command_brightness_parser_core.sv */
// channel  dir  handshake      payload
// rx_i     in   valid / ready  rx_byte
// tx_o     out  valid / ready  tx_byte, last, pwm_compare
//
// a byte inside a line is stored in the line ram and rx_i.ready stays high
// a line-ending byte drops ready: the scan reads one stored byte per cycle from the
//   line ram, then hands its registered result to the reply block, whose prep state
//   does the multiply
// each reply byte then goes out while tx_o.ready is high; a stall holds the byte
// reset clears fill count, brightness and control; the line ram is not cleared
module text_command_brightness_parser_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcbp_rx_if.sink   rx_i,
  tcbp_tx_if.source tx_o
);
  import tcbp_pkg::*;

  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              cr_q, cr_d;
  logic              busy_q, busy_d;
  logic              acc;
  logic              line_end;
  logic [CNT_W-1:0]  fill_inc;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  scan_res_t         res;
  logic              reply_done;

  assign rx_i.ready = !busy_q;
  assign acc        = rx_i.valid && !busy_q;
  assign fill_inc   = fill_q + CNT_W'(1);
  assign line_end   = ((rx_i.rx_byte == CH_LF) && cr_q) || (fill_inc == CNT_W'(LINE_BYTES));

  always_comb begin
    fill_d = fill_q;
    cr_d   = cr_q;
    busy_d = busy_q;
    if (acc) begin
      if (line_end) begin
        fill_d = '0;
        cr_d   = 1'b0;
        busy_d = 1'b1;
      end else begin
        fill_d = fill_inc;
        cr_d   = (rx_i.rx_byte == CH_CR);
      end
    end else if (reply_done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cr_q   <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      cr_q   <= cr_d;
      busy_q <= busy_d;
    end
  end

  tcbp_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (rx_i.rx_byte),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  tcbp_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (acc && line_end),
    .len_i     (fill_inc),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .res_o     (res)
  );

  tcbp_reply u_reply (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .done_o (reply_done),
    .tx_o   (tx_o)
  );

endmodule

/* src/tcbp_checker.sv */
`include "assert_macros.svh"

module tcbp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rx_valid_i,
  input logic                       rx_ready_i,
  input logic                       tx_valid_i,
  input logic                       tx_ready_i,
  input logic [7:0]                 tx_byte_i,
  input logic                       tx_last_i,
  input logic [tcbp_pkg::PWM_W-1:0] tx_pwm_i
);
  import tcbp_pkg::*;

  // stalled reply byte holds
  `TCBP_ASSERT_NEXT(a_tx_hold, clk_i, rst_ni, tx_valid_i && !tx_ready_i, tx_valid_i && $stable(tx_byte_i) && $stable(tx_last_i) && $stable(tx_pwm_i))

  // no new request taken while a reply is going out
  `TCBP_ASSERT_NOW(a_busy_reply, clk_i, rst_ni, tx_valid_i, !rx_ready_i)

  // compare value stays within brightness squared range
  `TCBP_ASSERT_NOW(a_pwm_range, clk_i, rst_ni, tx_valid_i, tx_pwm_i <= PWM_MAX)

  // a reply keeps one compare value and ends cleanly after its last byte
  `TCBP_ASSERT_NEXT(a_pwm_steady, clk_i, rst_ni, tx_valid_i && tx_ready_i && !tx_last_i, tx_valid_i && $stable(tx_pwm_i))
  `TCBP_ASSERT_NEXT(a_reply_end, clk_i, rst_ni, tx_valid_i && tx_ready_i && tx_last_i, !tx_valid_i)

endmodule

bind text_command_brightness_parser_core tcbp_checker u_tcbp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rx_valid_i (rx_i.valid),
  .rx_ready_i (rx_i.ready),
  .tx_valid_i (tx_o.valid),
  .tx_ready_i (tx_o.ready),
  .tx_byte_i  (tx_o.tx_byte),
  .tx_last_i  (tx_o.last),
  .tx_pwm_i   (tx_o.pwm_compare)
);
